FILE: sv/in_order_fragment_reassembler_macros.svh
// Assertion macros shared by the reassembler RTL.
`ifndef IN_ORDER_FRAGMENT_REASSEMBLER_MACROS_SVH
`define IN_ORDER_FRAGMENT_REASSEMBLER_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define OFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define OFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ofr_pkg.sv
// Types and constants shared by the fragment reassembler modules.
package ofr_pkg;

  localparam int unsigned STORE_BYTES_DEF = 16384;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam logic [14:0] CAPACITY_RESET  = 15'd16384;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_OUT_OF_SYNC = 2'd1,
    ST_OVERRUN     = 2'd2
  } status_t;

  typedef struct packed {
    logic        wr_en;
    logic [7:0]  wr_data;
    logic        has_result;
    status_t     status;
    logic        unit_complete;
    logic [14:0] unit_length;
  } ofr_item_t;

endpackage

FILE: sv/ofr_channels.sv
// Channel interfaces for input bytes, results and the capacity register.
interface ofr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_number;
  logic [15:0] fragment_number;
  logic        last_fragment;
  logic [14:0] chunk_length;
  logic        first_of_chunk;
  logic        end_of_chunk;
  logic [7:0]  data_byte;

  modport source (output valid, frame_number, fragment_number, last_fragment,
                  chunk_length, first_of_chunk, end_of_chunk, data_byte,
                  input ready);
  modport sink (input valid, frame_number, fragment_number, last_fragment,
                chunk_length, first_of_chunk, end_of_chunk, data_byte,
                output ready);
endinterface

interface ofr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        unit_complete;
  logic [14:0] unit_length;

  modport source (output valid, status, unit_complete, unit_length, input ready);
  modport sink (input valid, status, unit_complete, unit_length, output ready);
endinterface

interface ofr_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/ofr_front.sv
// Front end: header checks, assembly bookkeeping and store write planning.
module ofr_front
  import ofr_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
  parameter int unsigned AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  ofr_cfg_if.sink         cfg_chan,
  ofr_in_if.sink          in_chan,
  input  logic            q_full,
  output logic            push,
  output logic [AW-1:0]   push_addr,
  output ofr_item_t       push_item
);

  localparam int unsigned CAP_LIM = (STORE_BYTES < 32767) ? STORE_BYTES : 32767;
  localparam logic [14:0] CAP_LIM_W = 15'(CAP_LIM);

  logic [14:0] cap_r;
  logic [15:0] cur_frame_r, cur_frame_nxt;
  logic [15:0] exp_idx_r, exp_idx_nxt;
  logic [14:0] filled_r, filled_nxt;
  logic        active_r, active_nxt;
  status_t     verdict_r, verdict_nxt;
  logic [14:0] wpos_r, wpos_nxt;

  logic        restart;
  logic [14:0] cap_w;
  logic [14:0] base_filled;
  logic [15:0] base_idx;
  logic [14:0] room;
  logic [14:0] wpos_chk;
  logic        done;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !q_full;
  assign push           = in_chan.valid && !q_full;

  always_comb begin
    cap_w       = (cap_r > CAP_LIM_W) ? CAP_LIM_W : cap_r;
    restart     = !active_r || (in_chan.frame_number != cur_frame_r);
    base_filled = restart ? '0 : filled_r;
    base_idx    = restart ? '0 : exp_idx_r;
    room        = (base_filled < cap_w) ? (cap_w - base_filled) : '0;

    cur_frame_nxt = cur_frame_r;
    exp_idx_nxt   = exp_idx_r;
    filled_nxt    = filled_r;
    active_nxt    = active_r;
    verdict_nxt   = verdict_r;
    wpos_chk      = wpos_r;

    if (in_chan.first_of_chunk) begin
      cur_frame_nxt = in_chan.frame_number;
      exp_idx_nxt   = base_idx;
      filled_nxt    = base_filled;
      active_nxt    = 1'b1;
      wpos_chk      = base_filled;
      priority if (in_chan.fragment_number != base_idx) begin
        verdict_nxt = ST_OUT_OF_SYNC;
        active_nxt  = 1'b0;
      end else if (in_chan.chunk_length > room) begin
        verdict_nxt = ST_OVERRUN;
        active_nxt  = 1'b0;
      end else begin
        verdict_nxt = ST_ACCEPTED;
        filled_nxt  = base_filled + in_chan.chunk_length;
        exp_idx_nxt = base_idx + 16'd1;
      end
    end

    push_item.wr_en   = (verdict_nxt == ST_ACCEPTED) && (wpos_chk < filled_nxt);
    push_item.wr_data = in_chan.data_byte;
    push_addr         = AW'(wpos_chk);
    wpos_nxt          = push_item.wr_en ? (wpos_chk + 15'd1) : wpos_chk;

    done = in_chan.end_of_chunk && (verdict_nxt == ST_ACCEPTED) &&
           in_chan.last_fragment && active_nxt;

    push_item.has_result    = in_chan.end_of_chunk;
    push_item.status        = verdict_nxt;
    push_item.unit_complete = done;
    push_item.unit_length   = done ? filled_nxt : '0;
    if (done) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAPACITY_RESET;
      cur_frame_r <= '0;
      exp_idx_r   <= '0;
      filled_r    <= '0;
      active_r    <= 1'b0;
      verdict_r   <= ST_ACCEPTED;
      wpos_r      <= '0;
    end else begin
      if (cfg_chan.valid) begin
        cap_r <= cfg_chan.data;
      end
      if (push) begin
        cur_frame_r <= cur_frame_nxt;
        exp_idx_r   <= exp_idx_nxt;
        filled_r    <= filled_nxt;
        active_r    <= active_nxt;
        verdict_r   <= verdict_nxt;
        wpos_r      <= wpos_nxt;
      end
    end
  end

endmodule

FILE: sv/ofr_queue.sv
// Small FIFO between the front end and the back end.
module ofr_queue
  import ofr_pkg::*;
#(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : (wptr_r + PW'(1));
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : (rptr_r + PW'(1));
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/ofr_back.sv
// Back end: writes the assembly store and holds results for the output channel.
module ofr_back
  import ofr_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
  parameter int unsigned AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [AW-1:0] q_addr,
  input  ofr_item_t     q_item,
  output logic          pop,
  ofr_out_if.source     out_chan
);

  logic [7:0]  store_mem [STORE_BYTES];
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic        complete_r;
  logic [14:0] length_r;

  assign pop = !q_empty && (!q_item.has_result || !out_valid_r || out_chan.ready);

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.unit_complete = complete_r;
  assign out_chan.unit_length   = length_r;

  always_ff @(posedge clk) begin
    if (pop && q_item.wr_en) begin
      store_mem[q_addr] <= q_item.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && q_item.has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.has_result) begin
      status_r   <= q_item.status;
      complete_r <= q_item.unit_complete;
      length_r   <= q_item.unit_length;
    end
  end

endmodule

FILE: sv/in_order_fragment_reassembler.sv
// Top level of the in-order fragment reassembler.
// Takes one payload byte per clock while input ready is high, each tagged with
// its fragment header, and checks the header on the first byte of every
// fragment. The front end does the checks and the fill accounting per byte; a
// four-entry FIFO feeds the back end, which writes the byte store and registers
// the result of each fragment, so a result passes the FIFO and that register.
// Input ready drops only when the FIFO fills because results are not being
// taken. The byte store is never read here and needs no clearing.
`include "in_order_fragment_reassembler_macros.svh"
module in_order_fragment_reassembler
  import ofr_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ofr_cfg_if.sink   cfg_chan,
  ofr_in_if.sink    in_chan,
  ofr_out_if.source out_chan
);

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned QW = AW + $bits(ofr_item_t);

  logic          push, pop, q_full, q_empty;
  logic [AW-1:0] push_addr, q_addr;
  ofr_item_t     push_item, q_item;
  logic [QW-1:0] q_out;

  ofr_front #(.STORE_BYTES(STORE_BYTES), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_chan  (cfg_chan),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_addr (push_addr),
    .push_item (push_item)
  );

  ofr_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_item}),
    .pop       (pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_addr, q_item} = q_out;

  ofr_back #(.STORE_BYTES(STORE_BYTES), .AW(AW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_addr   (q_addr),
    .q_item   (q_item),
    .pop      (pop),
    .out_chan (out_chan)
  );

  `OFR_ASSERT_IMPL(a_no_push_when_full, in_chan.valid && in_chan.ready, !q_full, "Transfer accepted into a full queue.")
  `OFR_ASSERT_IMPL(a_complete_is_accepted, out_chan.valid && out_chan.unit_complete, out_chan.status == ST_ACCEPTED, "Completed unit without accepted status.")
  `OFR_ASSERT_IMPL(a_length_only_on_complete, out_chan.valid && !out_chan.unit_complete, out_chan.unit_length == 15'd0, "Nonzero length without completion.")

endmodule

FILE: sim/in_order_fragment_reassembler_tb.sv
// Self-checking testbench for the in-order fragment reassembler.
module in_order_fragment_reassembler_tb;
  import ofr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 10;
  localparam int IDLE_PERCENT = 17;
  localparam int PHASE_BYTES = 150;

  typedef struct packed {
    logic [15:0] frame;
    logic [15:0] index;
    logic        last_frag;
    logic [14:0] len;
    logic        first;
    logic        ends;
    logic [7:0]  data;
  } frag_byte_t;

  typedef struct packed {
    status_t     status;
    logic        complete;
    logic [14:0] length;
  } frag_result_t;

  typedef struct packed {
    frag_byte_t   item;
    logic         typed;
    frag_result_t result;
  } directed_row_t;

  localparam frag_result_t NO_RESULT = '{ST_ACCEPTED, 1'b0, 15'd0};

  localparam directed_row_t DIRECTED_ROWS [0:21] = '{
    '{'{16'h0000, 16'h0000, 1'b1, 15'd0, 1'b0, 1'b1, 8'h00}, 1'b1, NO_RESULT},
    '{'{16'hFFFF, 16'h0000, 1'b1, 15'd0, 1'b1, 1'b1, 8'hFF}, 1'b1,
      '{ST_ACCEPTED, 1'b1, 15'd0}},
    '{'{16'h1234, 16'h0000, 1'b1, 15'd16384, 1'b1, 1'b1, 8'h00}, 1'b1,
      '{ST_ACCEPTED, 1'b1, 15'd16384}},
    '{'{16'h2222, 16'h0000, 1'b1, 15'd16385, 1'b1, 1'b1, 8'h55}, 1'b1,
      '{ST_OVERRUN, 1'b0, 15'd0}},
    '{'{16'h3333, 16'hFFFF, 1'b1, 15'd0, 1'b1, 1'b1, 8'hAA}, 1'b1,
      '{ST_OUT_OF_SYNC, 1'b0, 15'd0}},
    '{'{16'h4444, 16'h0001, 1'b1, 15'd32767, 1'b1, 1'b1, 8'h0F}, 1'b1,
      '{ST_OUT_OF_SYNC, 1'b0, 15'd0}},
    '{'{16'hA5A5, 16'h0000, 1'b0, 15'd3, 1'b1, 1'b0, 8'h5A}, 1'b0, NO_RESULT},
    '{'{16'hA5A5, 16'h0000, 1'b0, 15'd3, 1'b0, 1'b0, 8'hA5}, 1'b0, NO_RESULT},
    '{'{16'hA5A5, 16'h0000, 1'b0, 15'd3, 1'b0, 1'b1, 8'h01}, 1'b0, NO_RESULT},
    '{'{16'hA5A5, 16'h0001, 1'b1, 15'd2, 1'b1, 1'b0, 8'h80}, 1'b0, NO_RESULT},
    '{'{16'hA5A5, 16'h0001, 1'b1, 15'd2, 1'b0, 1'b0, 8'h7F}, 1'b0, NO_RESULT},
    '{'{16'hA5A5, 16'h0001, 1'b1, 15'd2, 1'b0, 1'b1, 8'h10}, 1'b0, NO_RESULT},
    '{'{16'h0F0F, 16'h0000, 1'b0, 15'd4, 1'b1, 1'b0, 8'h11}, 1'b0, NO_RESULT},
    '{'{16'h0F0F, 16'h0000, 1'b1, 15'd4, 1'b1, 1'b1, 8'h22}, 1'b0, NO_RESULT},
    '{'{16'h0F0F, 16'h0005, 1'b1, 15'd0, 1'b0, 1'b1, 8'h44}, 1'b0, NO_RESULT},
    '{'{16'h00F0, 16'h0000, 1'b0, 15'd0, 1'b1, 1'b1, 8'hC3}, 1'b0, NO_RESULT},
    '{'{16'h00F0, 16'h0001, 1'b0, 15'd100, 1'b1, 1'b1, 8'h3C}, 1'b0, NO_RESULT},
    '{'{16'h00F0, 16'h0002, 1'b1, 15'd16284, 1'b1, 1'b1, 8'h99}, 1'b0, NO_RESULT},
    '{'{16'h00F0, 16'h0007, 1'b1, 15'd0, 1'b0, 1'b0, 8'h33}, 1'b0, NO_RESULT},
    '{'{16'h5555, 16'h0000, 1'b1, 15'd1, 1'b1, 1'b0, 8'h66}, 1'b0, NO_RESULT},
    '{'{16'h5555, 16'h0000, 1'b0, 15'd1, 1'b0, 1'b1, 8'h77}, 1'b0, NO_RESULT},
    '{'{16'h5555, 16'h0000, 1'b1, 15'd1, 1'b0, 1'b1, 8'h88}, 1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic steady = 1'b0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   bytes_sent = 0;

  logic [14:0] capacity_reg;
  logic [15:0] asm_frame;
  logic [15:0] asm_next_index;
  int unsigned asm_filled;
  logic        asm_active;
  status_t     asm_verdict;

  logic [15:0] unit_frame;
  logic [15:0] unit_next;

  frag_result_t expected_results [$];

  ofr_cfg_if cfg_chan ();
  ofr_in_if  in_chan ();
  ofr_out_if out_chan ();

  in_order_fragment_reassembler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    frag_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result count", 0, 1);
      end else begin
        want = expected_results.pop_front();
        if (out_chan.status !== want.status)
          report_mismatch("status", want.status, out_chan.status);
        if (out_chan.unit_complete !== want.complete)
          report_mismatch("unit_complete", want.complete, out_chan.unit_complete);
        if (out_chan.unit_length !== want.length)
          report_mismatch("unit_length", want.length, out_chan.unit_length);
      end
    end
  end

  function automatic void predict_fragment_result(input frag_byte_t b,
                                                  output bit emits,
                                                  output frag_result_t res);
    int unsigned cap;
    int unsigned room;
    if (b.first) begin
      cap = (capacity_reg > STORE_BYTES_DEF) ? STORE_BYTES_DEF : capacity_reg;
      if (!asm_active || b.frame != asm_frame) begin
        asm_frame = b.frame;
        asm_next_index = 16'd0;
        asm_filled = 0;
        asm_active = 1'b1;
      end
      room = (asm_filled < cap) ? cap - asm_filled : 0;
      if (b.index != asm_next_index) begin
        asm_verdict = ST_OUT_OF_SYNC;
        asm_active = 1'b0;
      end else if (b.len > room) begin
        asm_verdict = ST_OVERRUN;
        asm_active = 1'b0;
      end else begin
        asm_verdict = ST_ACCEPTED;
        asm_filled = asm_filled + b.len;
        asm_next_index = asm_next_index + 16'd1;
      end
    end
    emits = b.ends;
    res = '{asm_verdict, 1'b0, 15'd0};
    if (b.ends && asm_verdict == ST_ACCEPTED && b.last_frag && asm_active) begin
      res.complete = 1'b1;
      res.length = asm_filled[14:0];
      asm_active = 1'b0;
    end
  endfunction

  task automatic send_byte(input frag_byte_t b, input logic typed,
                           input frag_result_t typed_res);
    bit emits;
    frag_result_t res;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.frame_number    <= b.frame;
    in_chan.fragment_number <= b.index;
    in_chan.last_fragment   <= b.last_frag;
    in_chan.chunk_length    <= b.len;
    in_chan.first_of_chunk  <= b.first;
    in_chan.end_of_chunk    <= b.ends;
    in_chan.data_byte       <= b.data;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    predict_fragment_result(b, emits, res);
    if (emits) expected_results.push_back(typed ? typed_res : res);
    bytes_sent++;
  endtask

  task automatic send_fragment(input logic [15:0] frame, input logic [15:0] index,
                               input logic last_frag, input logic [14:0] len,
                               input int nbytes);
    frag_byte_t b;
    for (int k = 0; k < nbytes; k++) begin
      b = '{frame, index, last_frag, len, k == 0, k == nbytes - 1, 8'($urandom)};
      send_byte(b, 1'b0, NO_RESULT);
    end
  endtask

  task automatic write_capacity(input logic [14:0] value);
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (cfg_chan.ready !== 1'b1) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    capacity_reg = value;
  endtask

  function automatic logic [14:0] random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 15'($urandom_range(0, 6));
    if (pick < 90) return 15'($urandom_range(0, int'(capacity_reg) + 1));
    return 15'($urandom);
  endfunction

  task automatic run_random_phase(input int budget);
    int stop_at;
    int kind;
    int nfrag;
    int nbytes;
    logic [14:0] len;
    logic [15:0] idx;
    frag_byte_t b;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if ($urandom_range(0, 3) != 0) begin
          unit_frame = 16'($urandom);
          unit_next = 16'd0;
        end
        nfrag = $urandom_range(1, 4);
        for (int f = 0; f < nfrag; f++) begin
          len = random_length();
          if (len == 0) nbytes = 1;
          else if (len <= 6) nbytes = int'(len);
          else nbytes = $urandom_range(1, 3);
          idx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : unit_next;
          send_fragment(unit_frame, idx, f == nfrag - 1 && $urandom_range(0, 4) != 0,
                        len, nbytes);
          unit_next++;
        end
      end else if (kind < 85) begin
        nbytes = $urandom_range(1, 5);
        len = random_length();
        for (int k = 0; k < nbytes; k++) begin
          b = '{unit_frame, unit_next, 1'($urandom), len, 1'($urandom),
                1'($urandom), 8'($urandom)};
          send_byte(b, 1'b0, NO_RESULT);
        end
        if ($urandom_range(0, 1) == 0) unit_next++;
      end else begin
        b = '{16'($urandom), 16'($urandom), 1'($urandom), 15'($urandom),
              1'($urandom), 1'($urandom), 8'($urandom)};
        send_byte(b, 1'b0, NO_RESULT);
      end
    end
  endtask

  initial begin
    logic [14:0] phase_caps [6];
    rst_n                   <= 1'b0;
    cfg_chan.valid          <= 1'b0;
    cfg_chan.data           <= 15'd0;
    in_chan.valid           <= 1'b0;
    in_chan.frame_number    <= 16'd0;
    in_chan.fragment_number <= 16'd0;
    in_chan.last_fragment   <= 1'b0;
    in_chan.chunk_length    <= 15'd0;
    in_chan.first_of_chunk  <= 1'b0;
    in_chan.end_of_chunk    <= 1'b0;
    in_chan.data_byte       <= 8'd0;
    capacity_reg = CAPACITY_RESET;
    asm_frame = 16'd0;
    asm_next_index = 16'd0;
    asm_filled = 0;
    asm_active = 1'b0;
    asm_verdict = ST_ACCEPTED;
    unit_frame = 16'd0;
    unit_next = 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      send_byte(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);

    // Lowering the capacity below the bytes already filled leaves no room.
    send_fragment(16'h6666, 16'h0000, 1'b0, 15'd9000, 1);
    write_capacity(15'd20);
    send_fragment(16'h6666, 16'h0001, 1'b0, 15'd0, 1);
    send_fragment(16'h6666, 16'h0002, 1'b1, 15'd1, 1);

    phase_caps = '{15'd0, 15'd1, 15'd32767, 15'($urandom_range(2, 16383)),
                   15'd16384, 15'd64};
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      steady = (p == 2);
      run_random_phase(PHASE_BYTES);
    end
    steady = 1'b0;

    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/ofr_pkg.sv
sv/ofr_channels.sv
sv/ofr_front.sv
sv/ofr_queue.sv
sv/ofr_back.sv
sv/in_order_fragment_reassembler.sv
sim/in_order_fragment_reassembler_tb.sv
